/* hw/rtl/bgdm_pkg.sv */
// ----------------------------------------------------------------------------
// bgdm_pkg
// Shared types and constants of the button gesture and display manager:
// action codes, register indexes, result record and register reset values.
// ----------------------------------------------------------------------------
package bgdm_pkg;

  // field widths
  localparam int unsigned ELAPSED_W  = 21;
  localparam int unsigned DEB_W      = 10;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned RHOLD_W    = 20;
  localparam int unsigned GAP_W      = 16;
  localparam int unsigned TMO_W      = 20;
  localparam int unsigned PERIOD_W   = 20;
  localparam int unsigned PTOTAL_W   = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CLICK_W    = 3;

  // page count default
  localparam int unsigned MAX_PAGES_DEFAULT = 8;

  // register reset values
  localparam logic [DEB_W-1:0]    DEB_RESET    = DEB_W'(50);
  localparam logic [HOLD_W-1:0]   HOLD_RESET   = HOLD_W'(500);
  localparam logic [RHOLD_W-1:0]  RHOLD_RESET  = RHOLD_W'(5000);
  localparam logic [GAP_W-1:0]    GAP_RESET    = GAP_W'(400);
  localparam logic [TMO_W-1:0]    TMO_RESET    = TMO_W'(30000);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(5000);
  localparam logic [PTOTAL_W-1:0] PTOTAL_RESET = PTOTAL_W'(8);

  // saturation limits
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [DEB_W-1:0]     DEB_MAX     = '1;
  localparam logic [CLICK_W-1:0]   CLICK_MAX   = '1;

  // click counts that resolve to an action
  localparam logic [CLICK_W-1:0] CLICK_ONE   = CLICK_W'(1);
  localparam logic [CLICK_W-1:0] CLICK_TWO   = CLICK_W'(2);
  localparam logic [CLICK_W-1:0] CLICK_THREE = CLICK_W'(3);

  typedef enum logic [2:0] {
    ACT_NONE          = 3'd0,
    ACT_WAKE          = 3'd1,
    ACT_NEXT_PAGE     = 3'd2,
    ACT_PING          = 3'd3,
    ACT_REBOOT        = 3'd4,
    ACT_FACTORY_RESET = 3'd5,
    ACT_DISPLAY_OFF   = 3'd6
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 3'd0,
    CFG_HOLD       = 3'd1,
    CFG_RESET_HOLD = 3'd2,
    CFG_CLICK_GAP  = 3'd3,
    CFG_TIMEOUT    = 3'd4,
    CFG_PAGE_PER   = 3'd5,
    CFG_PAGE_TOTAL = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    action_e    action;
    logic       display_on;
    logic [2:0] page_index;
    logic       ping_pending;
    logic       button_held;
  } result_t;

endpackage

/* hw/rtl/button_gesture_display_manager_top.sv */
// ----------------------------------------------------------------------------
// button_gesture_display_manager_top
// Debounces a button, classifies clicks, holds and long holds, and manages
// display power and page rotation from millisecond tick transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o): one transaction per millisecond
//   tick with the raw button level, an activity poke and a ping acknowledge.
//   Output channel (out_valid_o / out_ready_i): exactly one result per input
//   transaction, in order: action code, display power, page, ping pending and
//   held flag.
//   Config channel (cfg_valid_i / cfg_ready_o): register index and data,
//   always ready; write only while no tick is in flight.
//   The result of an accepted tick is registered in the output register, or in
//   the skid register while the output stalls. Throughput is one tick per cycle
//   while in_ready_o is high; the state update is a single pass of counters and
//   compares between the tick acceptance and the result register.
//   A two-entry result buffer (output register plus skid register) lets the
//   block take one more tick while a result waits; in_ready_o drops only
//   when both entries are full.
//   Reset loads the register defaults, the display on, page zero, button
//   released and all timers cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
module button_gesture_display_manager_top #(
  parameter int unsigned MAX_PAGES = bgdm_pkg::MAX_PAGES_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tick input
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             button_level_i,
  input  logic                             activity_i,
  input  logic                             ping_ack_i,
  // result output
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0]                       action_o,
  output logic                             display_on_o,
  output logic [2:0]                       page_index_o,
  output logic                             ping_pending_o,
  output logic                             button_held_o,
  // register writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bgdm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bgdm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned TW = $clog2(MAX_PAGES + 1);
  localparam int unsigned KW = 2 * TW + 1;
  localparam int unsigned EW = bgdm_pkg::ELAPSED_W;

  // next page with wrap at tot, by picking the largest multiple of tot not above pg + 1
  function automatic logic [PW-1:0] wrap_next(logic [PW-1:0] pg, logic [TW-1:0] tot);
    logic [TW-1:0] nxt;
    logic [KW-1:0] prod;
    logic [TW-1:0] rem;
    nxt = TW'(pg) + TW'(1);
    rem = nxt;
    for (int k = 1; k <= int'(MAX_PAGES); k++) begin
      prod = KW'(k) * KW'(tot);
      if (prod <= KW'(nxt)) begin
        rem = nxt - prod[TW-1:0];
      end
    end
    return rem[PW-1:0];
  endfunction

  function automatic logic [EW-1:0] sat_inc(logic [EW-1:0] v);
    return (v == bgdm_pkg::ELAPSED_MAX) ? v : v + EW'(1);
  endfunction

  // configuration registers
  logic [bgdm_pkg::DEB_W-1:0]    deb_ticks_q;
  logic [bgdm_pkg::HOLD_W-1:0]   hold_ticks_q;
  logic [bgdm_pkg::RHOLD_W-1:0]  rhold_ticks_q;
  logic [bgdm_pkg::GAP_W-1:0]    gap_ticks_q;
  logic [bgdm_pkg::TMO_W-1:0]    tmo_ticks_q;
  logic [bgdm_pkg::PERIOD_W-1:0] period_ticks_q;
  logic [bgdm_pkg::PTOTAL_W-1:0] page_total_q;

  // gesture and display state
  logic                          stable_level_q, stable_level_d;
  logic [bgdm_pkg::DEB_W-1:0]    deb_cnt_q, deb_cnt_d;
  logic                          press_active_q, press_active_d;
  logic [EW-1:0]                 press_el_q, press_el_d;
  logic                          held_q, held_d;
  logic                          rfired_q, rfired_d;
  logic [bgdm_pkg::CLICK_W-1:0]  click_q, click_d;
  logic [EW-1:0]                 rel_el_q, rel_el_d;
  logic [EW-1:0]                 idle_el_q, idle_el_d;
  logic [EW-1:0]                 page_el_q, page_el_d;
  logic                          disp_q, disp_d;
  logic [PW-1:0]                 page_q, page_d;
  logic                          ping_q, ping_d;

  // result buffer
  logic                          out_valid_q;
  bgdm_pkg::result_t             out_q;
  logic                          skid_valid_q;
  bgdm_pkg::result_t             skid_q;
  bgdm_pkg::result_t             res_d;

  logic                          push;
  logic                          pop;
  logic [TW-1:0]                 tot;
  logic [4:0]                    tot_wide;
  logic [PW+2:0]                 page_ext;

  assign in_ready_o  = ~skid_valid_q;
  assign cfg_ready_o = 1'b1;
  assign push        = in_valid_i & in_ready_o;
  assign pop         = out_valid_q & out_ready_i;

  // page count clamped to one..MAX_PAGES
  always_comb begin
    if (page_total_q == '0) begin
      tot_wide = 5'd1;
    end else if ({1'b0, page_total_q} > 5'(MAX_PAGES)) begin
      tot_wide = 5'(MAX_PAGES);
    end else begin
      tot_wide = {1'b0, page_total_q};
    end
    tot = TW'(tot_wide);
  end

  // one tick of state update
  always_comb begin
    logic            fell;
    logic            rose;
    logic            fired;
    logic            off;
    logic            ping_set;
    bgdm_pkg::action_e click_act;

    fell      = 1'b0;
    rose      = 1'b0;
    fired     = 1'b0;
    off       = 1'b0;
    ping_set  = 1'b0;
    click_act = bgdm_pkg::ACT_NONE;

    stable_level_d = stable_level_q;
    deb_cnt_d      = deb_cnt_q;
    press_active_d = press_active_q;
    held_d         = held_q;
    rfired_d       = rfired_q;
    click_d        = click_q;
    disp_d         = disp_q;
    page_d         = page_q;
    ping_d         = ping_q;

    // elapsed timers
    idle_el_d  = sat_inc(idle_el_q);
    page_el_d  = sat_inc(page_el_q);
    rel_el_d   = sat_inc(rel_el_q);
    press_el_d = press_active_q ? sat_inc(press_el_q) : press_el_q;

    // debounce
    if (button_level_i != stable_level_q) begin
      if (deb_cnt_q != bgdm_pkg::DEB_MAX) begin
        deb_cnt_d = deb_cnt_q + bgdm_pkg::DEB_W'(1);
      end
      if (deb_cnt_d >= deb_ticks_q) begin
        stable_level_d = button_level_i;
        deb_cnt_d      = '0;
        fell           = ~button_level_i;
        rose           = button_level_i;
      end
    end else begin
      deb_cnt_d = '0;
    end

    // press start, long hold and hold tracking
    if (fell) begin
      press_active_d = 1'b1;
      press_el_d     = '0;
      held_d         = 1'b0;
      rfired_d       = 1'b0;
    end
    if (!stable_level_d && press_active_d) begin
      if (press_el_d >= EW'(rhold_ticks_q) && !rfired_d && disp_q) begin
        rfired_d = 1'b1;
        fired    = 1'b1;
      end
      held_d = press_el_d > EW'(hold_ticks_q);
    end

    // release counts a click unless it was a hold
    if (rose) begin
      rel_el_d = '0;
      if (press_active_d && !held_d && !rfired_d && click_q != bgdm_pkg::CLICK_MAX) begin
        click_d = click_q + bgdm_pkg::CLICK_W'(1);
      end
      press_active_d = 1'b0;
    end

    // click resolution after the release gap
    if (click_d != '0 && rel_el_d > EW'(gap_ticks_q)) begin
      if (click_d == bgdm_pkg::CLICK_ONE) begin
        idle_el_d = '0;
        if (!disp_q) begin
          disp_d    = 1'b1;
          click_act = bgdm_pkg::ACT_WAKE;
        end else begin
          page_d    = wrap_next(page_q, tot);
          page_el_d = '0;
          click_act = bgdm_pkg::ACT_NEXT_PAGE;
        end
      end else if (click_d == bgdm_pkg::CLICK_TWO && disp_q) begin
        ping_set  = 1'b1;
        click_act = bgdm_pkg::ACT_PING;
      end else if (click_d == bgdm_pkg::CLICK_THREE && disp_q) begin
        click_act = bgdm_pkg::ACT_REBOOT;
      end
      click_d = '0;
    end

    if (activity_i) idle_el_d = '0;
    if (ping_ack_i) ping_d = 1'b0;
    if (ping_set)   ping_d = 1'b1;

    // display timeout
    if (disp_d && idle_el_d > EW'(tmo_ticks_q)) begin
      disp_d = 1'b0;
      off    = 1'b1;
    end

    // automatic page rotation
    if (disp_d && page_el_d >= EW'(period_ticks_q)) begin
      page_d    = wrap_next(page_d, tot);
      page_el_d = '0;
    end

    // result record
    page_ext = (PW + 3)'(page_d);
    if (fired) begin
      res_d.action = bgdm_pkg::ACT_FACTORY_RESET;
    end else if (click_act != bgdm_pkg::ACT_NONE) begin
      res_d.action = click_act;
    end else if (off) begin
      res_d.action = bgdm_pkg::ACT_DISPLAY_OFF;
    end else begin
      res_d.action = bgdm_pkg::ACT_NONE;
    end
    res_d.display_on   = disp_d;
    res_d.page_index   = page_ext[2:0];
    res_d.ping_pending = ping_d;
    res_d.button_held  = held_d & press_active_d;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q    <= bgdm_pkg::DEB_RESET;
      hold_ticks_q   <= bgdm_pkg::HOLD_RESET;
      rhold_ticks_q  <= bgdm_pkg::RHOLD_RESET;
      gap_ticks_q    <= bgdm_pkg::GAP_RESET;
      tmo_ticks_q    <= bgdm_pkg::TMO_RESET;
      period_ticks_q <= bgdm_pkg::PERIOD_RESET;
      page_total_q   <= bgdm_pkg::PTOTAL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bgdm_pkg::cfg_idx_e'(cfg_index_i))
        bgdm_pkg::CFG_DEBOUNCE:   deb_ticks_q    <= cfg_data_i[bgdm_pkg::DEB_W-1:0];
        bgdm_pkg::CFG_HOLD:       hold_ticks_q   <= cfg_data_i[bgdm_pkg::HOLD_W-1:0];
        bgdm_pkg::CFG_RESET_HOLD: rhold_ticks_q  <= cfg_data_i[bgdm_pkg::RHOLD_W-1:0];
        bgdm_pkg::CFG_CLICK_GAP:  gap_ticks_q    <= cfg_data_i[bgdm_pkg::GAP_W-1:0];
        bgdm_pkg::CFG_TIMEOUT:    tmo_ticks_q    <= cfg_data_i[bgdm_pkg::TMO_W-1:0];
        bgdm_pkg::CFG_PAGE_PER:   period_ticks_q <= cfg_data_i[bgdm_pkg::PERIOD_W-1:0];
        bgdm_pkg::CFG_PAGE_TOTAL: page_total_q   <= cfg_data_i[bgdm_pkg::PTOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // state registers, updated on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_level_q <= 1'b1;
      deb_cnt_q      <= '0;
      press_active_q <= 1'b0;
      press_el_q     <= '0;
      held_q         <= 1'b0;
      rfired_q       <= 1'b0;
      click_q        <= '0;
      rel_el_q       <= '0;
      idle_el_q      <= '0;
      page_el_q      <= '0;
      disp_q         <= 1'b1;
      page_q         <= '0;
      ping_q         <= 1'b0;
    end else if (push) begin
      stable_level_q <= stable_level_d;
      deb_cnt_q      <= deb_cnt_d;
      press_active_q <= press_active_d;
      press_el_q     <= press_el_d;
      held_q         <= held_d;
      rfired_q       <= rfired_d;
      click_q        <= click_d;
      rel_el_q       <= rel_el_d;
      idle_el_q      <= idle_el_d;
      page_el_q      <= page_el_d;
      disp_q         <= disp_d;
      page_q         <= page_d;
      ping_q         <= ping_d;
    end
  end

  // result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  // result buffer data
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res_d;
      end
    end else if (push) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = out_q.action;
  assign display_on_o   = out_q.display_on;
  assign page_index_o   = out_q.page_index;
  assign ping_pending_o = out_q.ping_pending;
  assign button_held_o  = out_q.button_held;

`ifndef SYNTHESIS
  // skid entry only fills behind a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without output entry");

  // a transaction arriving at a stalled full output lands in the skid entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && out_valid_q && !out_ready_i |=> skid_valid_q)
    else $error("stalled transaction not kept in skid entry");

  // an open press always sits on a debounced low level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    press_active_q |-> !stable_level_q)
    else $error("press active while button released");

  // a wake leaves the display powered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && res_d.action == bgdm_pkg::ACT_WAKE |-> res_d.display_on)
    else $error("wake result with display off");
`endif

endmodule
